// ===== rtl/core/pibt_pkg.sv =====
// Package with shared constants, codes and control types of the port interval table.
package pibt_pkg;

    localparam int MAX_RANGES_DEF = 64;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;
    localparam logic [1:0] CMD_CHK = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_DECIDE,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PIECE0,
        ST_PIECE1,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic ready;
        logic load;
        logic scan_ev;
        logic decide;
        logic move_rd;
        logic move_wr;
        logic piece0;
        logic piece1;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic scan_end;
        logic apply;
        logic moves;
        logic move_last;
        logic two_pieces;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/pibt_if.sv =====
// Valid/ready channel interfaces for commands and results of the port interval table.
interface pibt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] range_low;
    logic [15:0] range_high;

    modport source (output valid, output command, output range_low, output range_high,
                    input ready);
    modport sink (input valid, input command, input range_low, input range_high,
                  output ready);
endinterface

interface pibt_rsp_if;
    logic       valid;
    logic       ready;
    logic       port_blocked;
    logic       status;
    logic [6:0] entry_count;

    modport source (output valid, output port_blocked, output status, output entry_count,
                    input ready);
    modport sink (input valid, input port_blocked, input status, input entry_count,
                  output ready);
endinterface

// ===== rtl/core/port_interval_block_table.sv =====
// Each table entry read by the scan and each entry shifted passes through a read state and
// then an evaluate or write state: the entry memory has one read and one write port and each
// entry passes through its registered read data. The scan stops one entry past the
// interval and only the entries after the interval are shifted; a check or an add that
// replaces entries in place works only on the entries up to the first entry past the
// interval. One command is worked on at a time; a new command transfer is taken once the
// previous result sits in the output register, even if that result has not been taken.
// The table needs no clearing pass after reset, since only entries below the count are read.
module port_interval_block_table
    import pibt_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    pibt_req_if.sink   req,
    pibt_rsp_if.source rsp
);

    // Command and status bundles between the sequencer and the datapath.
    ctl_t  ctl;
    stat_t stat;

    assign req.ready = ctl.ready;

    pibt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .stat      (stat),
        .ctl       (ctl)
    );

    // The datapath holds the sorted entries, the scan bounds and the result register.
    pibt_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .command      (req.command),
        .range_low    (req.range_low),
        .range_high   (req.range_high),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .port_blocked (rsp.port_blocked),
        .status       (rsp.status),
        .entry_count  (rsp.entry_count)
    );

endmodule

// ===== rtl/core/pibt_ctrl.sv =====
// Controller state machine that sequences scan, shift and write phases of one command.
module pibt_ctrl
    import pibt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = stat.scan_end ? ST_DECIDE : ST_SCAN_EV;
            end
            ST_SCAN_EV:
            begin
                ctl.scan_ev = 1'b1;
                state_next  = ST_SCAN_RD;
            end
            ST_DECIDE:
            begin
                ctl.decide = 1'b1;
                state_next = ST_RESULT;
                if (stat.apply)
                begin
                    state_next = stat.moves ? ST_MOVE_RD : ST_PIECE0;
                end
            end
            ST_MOVE_RD:
            begin
                ctl.move_rd = 1'b1;
                state_next  = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                ctl.move_wr = 1'b1;
                state_next  = stat.move_last ? ST_PIECE0 : ST_MOVE_RD;
            end
            ST_PIECE0:
            begin
                ctl.piece0 = 1'b1;
                state_next = stat.two_pieces ? ST_PIECE1 : ST_RESULT;
            end
            ST_PIECE1:
            begin
                ctl.piece1 = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/pibt_dp.sv =====
// Datapath of the port interval table: entry memory, scan registers and result register.
module pibt_dp
    import pibt_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    output stat_t       stat,
    input  logic [1:0]  command,
    input  logic [15:0] range_low,
    input  logic [15:0] range_high,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic        port_blocked,
    output logic        status,
    output logic [6:0]  entry_count
);

    localparam int AW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_RANGES);

    logic [31:0] mem [MAX_RANGES];
    logic [31:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        we;
    logic [AW-1:0] wa;
    logic [31:0] wd;

    logic [1:0]    cmd_reg;
    logic [15:0]   lo_reg, hi_reg, flo_reg, lhi_reg;
    logic [CW-1:0] count_reg, idx_reg, first_reg, last_reg;
    logic [CW-1:0] src_reg, dst_reg, mv_reg, newcnt_reg;
    logic          stop_reg, grow_reg, status_reg, blocked_reg;
    logic [1:0]    pc_reg;
    logic [15:0]   p0lo_reg, p0hi_reg, p1lo_reg, p1hi_reg;
    logic          out_valid_reg, out_blocked_reg, out_status_reg;
    logic [CW-1:0] out_count_reg;

    logic [15:0] e_lo, e_hi;
    logic [CW-1:0] span;
    logic [CW-1:0] pc_ext;
    logic [CW-1:0] d_mv;
    logic        d_apply, d_status, d_blocked, d_grow, d_shrink;
    logic [1:0]  d_pc;
    logic [15:0] d_p0lo, d_p0hi, d_p1lo, d_p1hi;
    logic        has_a, has_b;
    logic [CW+6:0] count_ext;

    assign e_lo = rd_data_reg[31:16];
    assign e_hi = rd_data_reg[15:0];

    assign rd_addr = ctl.move_rd ? src_reg[AW-1:0] : idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        we = 1'b0;
        wa = dst_reg[AW-1:0];
        wd = rd_data_reg;
        if (ctl.move_wr)
        begin
            we = 1'b1;
        end
        else if (ctl.piece0)
        begin
            we = (pc_reg != 2'd0);
            wa = first_reg[AW-1:0];
            wd = {p0lo_reg, p0hi_reg};
        end
        else if (ctl.piece1)
        begin
            we = 1'b1;
            wa = first_reg[AW-1:0] + AW'(1);
            wd = {p1lo_reg, p1hi_reg};
        end
    end

    // Decision taken once the span of intersecting entries is known.
    always_comb
    begin
        span      = last_reg - first_reg;
        d_apply   = 1'b0;
        d_status  = 1'b0;
        d_blocked = 1'b0;
        d_pc      = 2'd0;
        d_p0lo    = lo_reg;
        d_p0hi    = hi_reg;
        d_p1lo    = hi_reg + 16'd1;
        d_p1hi    = lhi_reg;
        has_a     = flo_reg < lo_reg;
        has_b     = lhi_reg > hi_reg;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (span == '0)
                begin
                    if (count_reg >= MAX_C)
                    begin
                        d_status = 1'b1;
                    end
                    else
                    begin
                        d_apply = 1'b1;
                        d_pc    = 2'd1;
                    end
                end
                else
                begin
                    d_apply = 1'b1;
                    d_pc    = 2'd1;
                    d_p0lo  = has_a ? flo_reg : lo_reg;
                    d_p0hi  = has_b ? lhi_reg : hi_reg;
                end
            end
            CMD_DEL:
            begin
                if (span != '0)
                begin
                    d_pc = {1'b0, has_a} + {1'b0, has_b};
                    if (has_a)
                    begin
                        d_p0lo = flo_reg;
                        d_p0hi = lo_reg - 16'd1;
                    end
                    else
                    begin
                        d_p0lo = hi_reg + 16'd1;
                        d_p0hi = lhi_reg;
                    end
                    if (d_pc == 2'd2 && span == CW'(1) && count_reg == MAX_C)
                    begin
                        d_status = 1'b1;
                    end
                    else
                    begin
                        d_apply = 1'b1;
                    end
                end
            end
            CMD_CHK:
            begin
                d_blocked = (span != '0);
            end
            default:
            begin
                d_apply = 1'b0;
            end
        endcase
        pc_ext   = CW'(d_pc);
        d_grow   = pc_ext > span;
        d_shrink = pc_ext < span;
        d_mv     = (d_grow || d_shrink) ? (count_reg - last_reg) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= command;
            if (command == CMD_CHK)
            begin
                lo_reg <= range_low;
                hi_reg <= range_low;
            end
            else
            begin
                lo_reg <= (range_low < range_high) ? range_low : range_high;
                hi_reg <= (range_low < range_high) ? range_high : range_low;
            end
            idx_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        if (ctl.scan_ev)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (e_hi < lo_reg)
            begin
                first_reg <= idx_reg + CW'(1);
                last_reg  <= idx_reg + CW'(1);
            end
            else if (e_lo <= hi_reg)
            begin
                if (last_reg == first_reg)
                begin
                    flo_reg <= e_lo;
                end
                lhi_reg  <= e_hi;
                last_reg <= idx_reg + CW'(1);
            end
            else
            begin
                stop_reg <= 1'b1;
            end
        end
        if (ctl.decide)
        begin
            status_reg  <= d_status;
            blocked_reg <= d_blocked;
            pc_reg      <= d_pc;
            grow_reg    <= d_grow;
            p0lo_reg    <= d_p0lo;
            p0hi_reg    <= d_p0hi;
            p1lo_reg    <= d_p1lo;
            p1hi_reg    <= d_p1hi;
            newcnt_reg  <= count_reg - span + pc_ext;
            mv_reg      <= d_mv;
            src_reg     <= d_grow ? (count_reg - CW'(1)) : last_reg;
            dst_reg     <= d_grow ? count_reg : (first_reg + pc_ext);
        end
        if (ctl.move_wr)
        begin
            mv_reg  <= mv_reg - CW'(1);
            src_reg <= grow_reg ? (src_reg - CW'(1)) : (src_reg + CW'(1));
            dst_reg <= grow_reg ? (dst_reg - CW'(1)) : (dst_reg + CW'(1));
        end
        if (ctl.finish)
        begin
            out_blocked_reg <= blocked_reg;
            out_status_reg  <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            if (ctl.piece0)
            begin
                count_reg <= newcnt_reg;
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
                out_count_reg <= count_reg;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {7'd0, out_count_reg};

    assign stat.scan_end   = (idx_reg == count_reg) || stop_reg;
    assign stat.apply      = d_apply;
    assign stat.moves      = (d_mv != '0);
    assign stat.move_last  = (mv_reg == CW'(1));
    assign stat.two_pieces = (pc_reg == 2'd2);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid    = out_valid_reg;
    assign port_blocked = out_blocked_reg;
    assign status       = out_status_reg;
    assign entry_count  = count_ext[6:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("entry count exceeds table size");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish && status_reg |-> count_reg == MAX_C)
        else $error("command rejected while table not full");

    a_second_piece: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.piece1 |-> pc_reg == 2'd2 && $past(ctl.piece0))
        else $error("second piece written without a split");

endmodule

// ===== verif/tb.sv =====
// Testbench for the blocked port interval table: directed and random commands against a predictor.
module tb;
    import pibt_pkg::*;

    localparam int DEPTH = MAX_RANGES_DEF;

    typedef struct packed {
        logic       port_blocked;
        logic       status;
        logic [6:0] entry_count;
    } reply_t;

    logic clk;
    logic rst_n;

    pibt_req_if req ();
    pibt_rsp_if rsp ();

    port_interval_block_table #(.MAX_RANGES(DEPTH)) i_dut
    (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    // The predictor keeps its own copy of the sorted interval table.
    logic [15:0] blk_lo [DEPTH];
    logic [15:0] blk_hi [DEPTH];
    int          blk_count;

    // Replies that the block still owes us, oldest first.
    reply_t      pending_replies [$];
    int          error_count;
    int          replies_seen;
    int          items_sent;

    // Idling controls: chance in percent that a side holds off in a given cycle.
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Replace entries [first, last) by up to two new pieces.
    function automatic void splice_table(int first, int last,
                                         logic [15:0] plo [2], logic [15:0] phi [2],
                                         int pieces);
        logic [15:0] tlo [DEPTH];
        logic [15:0] thi [DEPTH];
        int          n;
        n = 0;
        for (int k = 0; k < first; k++)
        begin
            tlo[n] = blk_lo[k];
            thi[n] = blk_hi[k];
            n++;
        end
        for (int k = 0; k < pieces; k++)
        begin
            tlo[n] = plo[k];
            thi[n] = phi[k];
            n++;
        end
        for (int k = last; k < blk_count; k++)
        begin
            tlo[n] = blk_lo[k];
            thi[n] = blk_hi[k];
            n++;
        end
        blk_lo    = tlo;
        blk_hi    = thi;
        blk_count = n;
    endfunction

    // Apply one command to the predicted table and return the reply it should give.
    function automatic reply_t predict_table_reply(logic [1:0] cmd, logic [15:0] a,
                                                   logic [15:0] b);
        reply_t      r;
        logic [15:0] lo, hi;
        logic [15:0] plo [2];
        logic [15:0] phi [2];
        int          first, last, pieces;
        r      = '0;
        lo     = (a < b) ? a : b;
        hi     = (a < b) ? b : a;
        pieces = 0;
        first  = 0;
        while (first < blk_count && blk_hi[first] < lo)
            first++;
        last = first;
        while (last < blk_count && blk_lo[last] <= hi)
            last++;
        if (cmd == CMD_ADD)
        begin
            if (first == last)
            begin
                if (blk_count >= DEPTH)
                    r.status = 1'b1;
                else
                begin
                    plo[0] = lo;
                    phi[0] = hi;
                    splice_table(first, first, plo, phi, 1);
                end
            end
            else
            begin
                plo[0] = (blk_lo[first] < lo) ? blk_lo[first] : lo;
                phi[0] = (blk_hi[last-1] > hi) ? blk_hi[last-1] : hi;
                splice_table(first, last, plo, phi, 1);
            end
        end
        else if (cmd == CMD_DEL)
        begin
            if (first != last)
            begin
                if (blk_lo[first] < lo)
                begin
                    plo[pieces] = blk_lo[first];
                    phi[pieces] = lo - 16'd1;
                    pieces++;
                end
                if (blk_hi[last-1] > hi)
                begin
                    plo[pieces] = hi + 16'd1;
                    phi[pieces] = blk_hi[last-1];
                    pieces++;
                end
                if (pieces > last - first && blk_count + pieces - (last - first) > DEPTH)
                    r.status = 1'b1;
                else
                    splice_table(first, last, plo, phi, pieces);
            end
        end
        else if (cmd == CMD_CHK)
        begin
            for (int k = 0; k < blk_count; k++)
            begin
                if (blk_lo[k] > a)
                    break;
                if (a <= blk_hi[k])
                begin
                    r.port_blocked = 1'b1;
                    break;
                end
            end
        end
        r.entry_count = blk_count[6:0];
        return r;
    endfunction

    // Offer one command, wait for its transfer, and record the expected reply.
    // Valid stays up after the transfer until the next command or a drain decides.
    task automatic send_command(logic [1:0] cmd, logic [15:0] a, logic [15:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.range_low  <= a;
        req.range_high <= b;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_replies.push_back(predict_table_reply(cmd, a, b));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_replies.size() != 0);
    endtask

    // Receiver: random stalls, plus a long counted hold-off on request.
    initial
    begin
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each reply transfer is compared against the oldest expectation.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected reply: blocked=%0b status=%0b count=%0d",
                       rsp.port_blocked, rsp.status, rsp.entry_count);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp.port_blocked !== want.port_blocked)
                begin
                    $error("port_blocked: expected %0b, got %0b", want.port_blocked,
                           rsp.port_blocked);
                    error_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0b, got %0b", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           rsp.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Random port biased toward a small window so intervals collide often,
    // with occasional full-range values to toggle every bit.
    function automatic logic [15:0] rand_port();
        if ($urandom_range(9) == 0)
            return 16'($urandom);
        return 16'($urandom_range(400));
    endfunction

    task automatic test_directed();
        send_command(CMD_CHK, 16'd0, 16'd0);
        send_command(CMD_DEL, 16'd5, 16'd9);          // delete hitting nothing
        send_command(CMD_ADD, 16'd20, 16'd10);        // swapped bounds
        send_command(CMD_CHK, 16'd10, 16'hFFFF);
        send_command(CMD_CHK, 16'd21, 16'd0);
        send_command(CMD_ADD, 16'd21, 16'd30);        // adjacent, stays separate
        send_command(CMD_ADD, 16'd40, 16'd50);
        send_command(CMD_ADD, 16'd25, 16'd45);        // merges two entries
        send_command(CMD_DEL, 16'd15, 16'd12);        // split, swapped bounds
        send_command(CMD_DEL, 16'd0, 16'd13);         // removes an entry fully
        send_command(CMD_DEL, 16'd14, 16'd100);       // covers entries fully
        send_command(CMD_ADD, 16'hFFFF, 16'hFFFF);
        send_command(CMD_ADD, 16'd0, 16'd0);
        send_command(CMD_CHK, 16'hFFFF, 16'd0);
        send_command(CMD_NOP, 16'hFFFF, 16'hFFFF);    // unused code, no operation
        send_command(CMD_ADD, 16'd0, 16'hFFFF);
        send_command(CMD_DEL, 16'hFFFF, 16'd0);
        wait_drained();
    endtask

    // Fill the table to its limit, then overflow it by add and by split.
    task automatic test_full_table();
        for (int k = 0; k < DEPTH; k++)
            send_command(CMD_ADD, 16'(k * 10), 16'(k * 10 + 5));
        send_command(CMD_ADD, 16'd2000, 16'd2001);
        send_command(CMD_DEL, 16'd12, 16'd13);
        send_command(CMD_ADD, 16'd3, 16'd12);
        send_command(CMD_DEL, 16'd100, 16'd100);
        send_command(CMD_DEL, 16'd0, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [1:0] cmd;
        int         pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            cmd  = (pick < 40) ? CMD_ADD : (pick < 65) ? CMD_DEL :
                   (pick < 97) ? CMD_CHK : CMD_NOP;
            send_command(cmd, rand_port(), rand_port());
        end
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        hold_cycles = 2000;
        test_random(20);
        wait_drained();
    endtask

    initial
    begin
        req.valid      = 1'b0;
        req.command    = CMD_CHK;
        req.range_low  = '0;
        req.range_high = '0;
        rst_n          = 1'b0;
        blk_count      = 0;
        error_count    = 0;
        replies_seen   = 0;
        items_sent     = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random(150);
        send_idle_pct  = 81;
        test_random(150);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 81;
        test_random(150);
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        test_random(150);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();
        repeat (300) @(negedge clk);

        $display("Covered %0d commands with %0d replies checked, table full and overflow cases",
                 items_sent, replies_seen);
        $display("included, under sender gaps, receiver stalls and a long output hold-off.");
        if (error_count == 0 && pending_replies.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
